// ===== rtl/dvtu_pkg.sv =====
// Types and constants shared by the distance-vector table update block.
`default_nettype none
package dvtu_pkg;

  localparam int ADDR_W = 32;
  localparam int COST_W = 16;
  localparam int SLOT_W = 6;
  localparam int ACT_W  = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_SAME  = 2'd0,
    ACT_LOWER = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_FULL  = 2'd3
  } action_t;

  // Query token that walks the cell chain, one cell per cycle while the chain advances.
  typedef struct packed {
    logic              vld;
    logic              done;
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cand_cost;
    logic [ADDR_W-1:0] sender;
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [COST_W-1:0] res_cost;
    logic [ADDR_W-1:0] res_hop;
  } token_t;

endpackage
`default_nettype wire

// ===== rtl/dvtu_if.sv =====
// Valid/ready channel interfaces for advertisement input and update result.
`default_nettype none
interface dvtu_in_if;
  logic                        valid;
  logic                        ready;
  logic [dvtu_pkg::ADDR_W-1:0] dest_addr;
  logic [dvtu_pkg::COST_W-1:0] adv_cost;
  logic [dvtu_pkg::ADDR_W-1:0] sender_addr;
  logic [dvtu_pkg::ADDR_W-1:0] recv_iface_addr;
  logic [dvtu_pkg::COST_W-1:0] link_cost;

  modport source (output valid, dest_addr, adv_cost, sender_addr, recv_iface_addr,
                  link_cost, input ready);
  modport sink   (input valid, dest_addr, adv_cost, sender_addr, recv_iface_addr,
                  link_cost, output ready);
endinterface

interface dvtu_out_if;
  logic                        valid;
  logic                        ready;
  logic [dvtu_pkg::ACT_W-1:0]  action;
  logic [dvtu_pkg::SLOT_W-1:0] slot;
  logic [dvtu_pkg::COST_W-1:0] route_cost;
  logic [dvtu_pkg::ADDR_W-1:0] route_next_hop;

  modport source (output valid, action, slot, route_cost, route_next_hop, input ready);
  modport sink   (input valid, action, slot, route_cost, route_next_hop, output ready);
endinterface
`default_nettype wire

// ===== rtl/dvtu_cell.sv =====
// One routing table entry with its stage of the query chain.
`default_nettype none
module dvtu_cell #(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire dvtu_pkg::token_t  tok_i,
  output dvtu_pkg::token_t       tok_o,
  output logic                   ent_vld
);

  logic                          ent_vld_r;
  logic [dvtu_pkg::ADDR_W-1:0]   ent_dest_r;
  logic [dvtu_pkg::ADDR_W-1:0]   ent_hop_r;
  logic [dvtu_pkg::COST_W-1:0]   ent_cost_r;
  dvtu_pkg::token_t              tok_r;
  dvtu_pkg::token_t              tok_nxt;

  logic live;
  logic hit;
  logic lower;
  logic claim;

  // query still open when it reaches this cell
  assign live  = tok_i.vld && !tok_i.done;
  assign hit   = live && ent_vld_r && (ent_dest_r == tok_i.dest);
  assign lower = hit && (ent_cost_r > tok_i.cand_cost);
  // valid slots are contiguous, so the first empty cell is the append slot
  assign claim = live && !ent_vld_r;

  // resolve the query here if this entry matches or is the append slot
  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.done     = 1'b1;
      tok_nxt.slot     = dvtu_pkg::SLOT_W'(INDEX);
      tok_nxt.action   = lower ? dvtu_pkg::ACT_LOWER : dvtu_pkg::ACT_SAME;
      tok_nxt.res_cost = lower ? tok_i.cand_cost : ent_cost_r;
      tok_nxt.res_hop  = lower ? tok_i.sender : ent_hop_r;
    end else if (claim) begin
      tok_nxt.done     = 1'b1;
      tok_nxt.slot     = dvtu_pkg::SLOT_W'(INDEX);
      tok_nxt.action   = dvtu_pkg::ACT_ADD;
      tok_nxt.res_cost = tok_i.cand_cost;
      tok_nxt.res_hop  = tok_i.sender;
    end
  end

  // entry storage: append or relax on the way through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (adv && claim) begin
      ent_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && claim) begin
      ent_dest_r <= tok_i.dest;
      ent_hop_r  <= tok_i.sender;
      ent_cost_r <= tok_i.cand_cost;
    end else if (adv && lower) begin
      ent_hop_r  <= tok_i.sender;
      ent_cost_r <= tok_i.cand_cost;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o   = tok_r;
  assign ent_vld = ent_vld_r;

endmodule
`default_nettype wire

// ===== rtl/distance_vector_table_update.sv =====
// Top level: distance-vector route table as a chain of entry cells.
// A result word is held in each cell's token register in turn, then in the output register.
// Throughput: one word per cycle unless stalled; each query one cell behind the last.
// The whole chain and the output register stall together while a result waits.
// Reset (synchronous, rst_n low) empties the table at once and drops words in flight.
`default_nettype none
module distance_vector_table_update #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dvtu_in_if.sink    in_ch,
  dvtu_out_if.source out_ch
);

  dvtu_pkg::token_t tok   [TABLE_DEPTH+1];
  dvtu_pkg::token_t tail;
  logic [TABLE_DEPTH-1:0] vld_vec;

  logic                        adv;
  logic [dvtu_pkg::COST_W:0]   sum;
  logic [dvtu_pkg::COST_W-1:0] cand;

  logic                        out_vld_r;
  dvtu_pkg::action_t           out_act_r;
  logic [dvtu_pkg::SLOT_W-1:0] out_slot_r;
  logic [dvtu_pkg::COST_W-1:0] out_cost_r;
  logic [dvtu_pkg::ADDR_W-1:0] out_hop_r;

  // chain moves whenever the output register can take the tail
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // saturating candidate cost
  assign sum  = {1'b0, in_ch.adv_cost} + {1'b0, in_ch.link_cost};
  assign cand = sum[dvtu_pkg::COST_W] ? dvtu_pkg::COST_MAX : sum[dvtu_pkg::COST_W-1:0];

  // head token
  always_comb begin
    tok[0]           = '0;
    tok[0].vld       = in_ch.valid;
    tok[0].dest      = in_ch.dest_addr;
    tok[0].cand_cost = cand;
    tok[0].sender    = in_ch.sender_addr;
  end

  // entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dvtu_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1]),
      .ent_vld (vld_vec[i])
    );
  end

  assign tail = tok[TABLE_DEPTH];

  // output register; an unresolved query means the table is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tail.done) begin
        out_act_r  <= tail.action;
        out_slot_r <= tail.slot;
        out_cost_r <= tail.res_cost;
        out_hop_r  <= tail.res_hop;
      end else begin
        out_act_r  <= dvtu_pkg::ACT_FULL;
        out_slot_r <= '0;
        out_cost_r <= '0;
        out_hop_r  <= '0;
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.action         = out_act_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.route_cost     = out_cost_r;
  assign out_ch.route_next_hop = out_hop_r;

  // occupied entries always form a prefix of the table
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, vld_vec} + {{TABLE_DEPTH{1'b0}}, 1'b1}))
    else $error("table valid bits not contiguous");

  // a drop is reported only when every entry is in use
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_act_r == dvtu_pkg::ACT_FULL) |-> (&vld_vec))
    else $error("drop reported with free entries");

  // a dropped word carries zero fields
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_act_r == dvtu_pkg::ACT_FULL) |->
      (out_slot_r == '0 && out_cost_r == '0 && out_hop_r == '0))
    else $error("dropped word has nonzero fields");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_vld_r)
    else $error("result right after reset");

endmodule
`default_nettype wire
